/* rtl/ppfq_pkg.sv */
`default_nettype none
package ppfq_pkg;

    // field and datapath widths
    localparam int CB    = 24;            // position coordinate
    localparam int NFB   = 14;            // normal fraction bits
    localparam int NW    = NFB + 2;       // normal and angle key field
    localparam int DB    = CB + 1;        // difference, norm, distance key
    localparam int SQB   = 2 * CB + 2;    // squared length
    localparam int DOTB  = NW + DB + 2;   // normal dot difference
    localparam int N2B   = 2 * NW + 2;    // normal dot normal
    localparam int AB    = 15;            // angle step
    localparam int MAXDB = 25;            // distance limit
    localparam int DSB   = 25;            // distance step
    localparam int DENB  = DB + AB;       // norm times angle step
    localparam int QB    = NFB + 1;       // angle quotient bits below saturation
    localparam int REMB  = DOTB - 1;      // dividend magnitude
    localparam int CMPB  = DENB + DB;     // shifted divisor compare width
    localparam int TDI   = 6 * CB + 6 * NW;
    localparam int TDO   = ((3 * NW + DB + 7) / 8) * 8;
    localparam int AW    = 4;
    localparam int PW    = 32;

    // status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FAR   = 2'd1;
    localparam t_status ST_COINC = 2'd2;

    // register indexes
    localparam logic [1:0] REG_MAXD  = 2'd0;
    localparam logic [1:0] REG_ASTEP = 2'd1;
    localparam logic [1:0] REG_DSTEP = 2'd2;

    localparam logic [MAXDB-1:0] MAXD_RST  = 25'd33554431;
    localparam logic [AB-1:0]    ASTEP_RST = 15'd1024;
    localparam logic [DSB-1:0]   DSTEP_RST = 25'd64;

    // beat carried through the square root cells
    typedef struct packed {
        t_status                status;
        logic [SQB-1:0]         rem;
        logic [DB-1:0]          res;
        logic signed [DOTB-1:0] dot1;
        logic signed [DOTB-1:0] dot2;
        logic signed [N2B-1:0]  dot3;
    } t_sqrt_beat;

    // beat carried through the divider cells, lanes k1 k2 k3 k4
    typedef struct packed {
        t_status                 status;
        logic [2:0]              neg;
        logic [2:0]              sat;
        logic [3:0][REMB-1:0]    rem;
        logic [3:0][DENB-1:0]    den;
        logic [3:0][DB-1:0]      quo;
    } t_div_beat;

endpackage
`default_nettype wire

/* rtl/point_pair_feature_quantizer.sv */
`default_nettype none
// channel   direction  handshake                   payload
// s         in         i_s_tvalid / o_s_tready     i_s_tdata: point pair, 240 bits
// m         out        o_m_tvalid / i_m_tready     o_m_tdata: four keys, o_m_tuser: status
// apb       in         i_psel / i_penable          limit, angle step, distance step
//
// one point pair per cycle unless the output holds; stages in order: three arithmetic
// stages, 25 square root cells (one norm bit each), the divisor stage, 25 divider
// cells (one quotient bit each on four lanes) and the output register.
// synchronous active-low reset clears the valid bits and loads the register defaults.
// the whole pipeline holds while a result waits at the output; bubbles stay in place.
module point_pair_feature_quantizer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // fpx fpy fpz fnx fny fnz spx spy spz snx sny snz, lowest bit up
    input  logic [ppfq_pkg::TDI-1:0]    i_s_tdata,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // key_first_angle key_second_angle key_normal_angle key_distance, lowest bit up
    output logic [ppfq_pkg::TDO-1:0]    o_m_tdata,
    // status
    output logic [1:0]                  o_m_tuser,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [ppfq_pkg::AW-1:0]     i_paddr,
    input  logic [ppfq_pkg::PW-1:0]     i_pwdata,
    output logic [ppfq_pkg::PW-1:0]     o_prdata,
    output logic                        o_pready
);
    import ppfq_pkg::*;

    logic              w_en;
    logic [MAXDB-1:0]  r_maxd;
    logic [AB-1:0]     r_astep;
    logic [DSB-1:0]    r_dstep;
    logic [AB-1:0]     w_astep;
    logic [DSB-1:0]    w_dstep;

    // stage a
    logic                   r_a_valid;
    logic signed [DB-1:0]   r_a_d  [3];
    logic signed [NW-1:0]   r_a_n1 [3];
    logic signed [NW-1:0]   r_a_n2 [3];
    logic signed [CB-1:0]   w_p1 [3];
    logic signed [CB-1:0]   w_p2 [3];
    // stage b
    logic                   r_b_valid;
    logic [2*CB-1:0]        r_b_sq [3];
    logic signed [DOTB-1:0] r_b_p1 [3];
    logic signed [DOTB-1:0] r_b_p2 [3];
    logic signed [N2B-1:0]  r_b_p3 [3];
    logic [SQB-1:0]         r_b_lim2;
    logic [CB-1:0]          w_ad [3];
    // stage c
    logic                   r_c_valid;
    logic [SQB-1:0]         r_c_sq;
    logic signed [DOTB-1:0] r_c_dot1;
    logic signed [DOTB-1:0] r_c_dot2;
    logic signed [N2B-1:0]  r_c_dot3;
    logic [SQB-1:0]         r_c_lim2;
    // cell chains
    t_sqrt_beat             w_sq_beat  [DB+1];
    logic                   w_sq_valid [DB+1];
    t_div_beat              w_dv_beat  [DB+1];
    logic                   w_dv_valid [DB+1];
    // stage e
    logic                   r_e_valid;
    t_status                r_e_status;
    logic [DB-1:0]          r_e_norm;
    logic [DENB-1:0]        r_e_den;
    logic [REMB-1:0]        r_e_abs [3];
    logic [2:0]             r_e_neg;
    // output
    logic                   r_o_valid;
    logic [TDO-1:0]         r_o_data;
    t_status                r_o_user;
    logic signed [NW-1:0]   w_k [3];
    logic [DB-1:0]          w_k4;
    t_div_beat              w_last;

    // pipeline advances unless a result is held at the output
    assign w_en       = !r_o_valid || i_m_tready;
    assign o_s_tready = w_en;
    assign o_pready   = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maxd  <= MAXD_RST;
            r_astep <= ASTEP_RST;
            r_dstep <= DSTEP_RST;
        end else if (i_psel && i_penable && i_pwrite) begin
            unique case (i_paddr[3:2])
                REG_MAXD:  r_maxd  <= i_pwdata[MAXDB-1:0];
                REG_ASTEP: r_astep <= i_pwdata[AB-1:0];
                REG_DSTEP: r_dstep <= i_pwdata[DSB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[3:2])
            REG_MAXD:  o_prdata = PW'(r_maxd);
            REG_ASTEP: o_prdata = PW'(r_astep);
            REG_DSTEP: o_prdata = PW'(r_dstep);
            default:   o_prdata = '0;
        endcase
    end

    assign w_astep = (r_astep == '0) ? AB'(1) : r_astep;
    assign w_dstep = (r_dstep == '0) ? DSB'(1) : r_dstep;

    // stage a: unpack and difference vector
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_p1[k] = i_s_tdata[CB*k +: CB];
            w_p2[k] = i_s_tdata[3*CB + 3*NW + CB*k +: CB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_a_d[k]  <= DB'(w_p2[k]) - DB'(w_p1[k]);
                r_a_n1[k] <= i_s_tdata[3*CB + NW*k +: NW];
                r_a_n2[k] <= i_s_tdata[6*CB + 3*NW + NW*k +: NW];
            end
        end
    end

    // stage b: squares and products
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_ad[k] = r_a_d[k][DB-1] ? CB'(-r_a_d[k]) : CB'(r_a_d[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_b_sq[k] <= (2*CB)'(w_ad[k]) * (2*CB)'(w_ad[k]);
                r_b_p1[k] <= DOTB'(r_a_n1[k]) * DOTB'(r_a_d[k]);
                r_b_p2[k] <= DOTB'(r_a_n2[k]) * DOTB'(r_a_d[k]);
                r_b_p3[k] <= N2B'(r_a_n1[k]) * N2B'(r_a_n2[k]);
            end
            r_b_lim2 <= SQB'(r_maxd) * SQB'(r_maxd);
        end
    end

    // stage c: sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_sq   <= SQB'(r_b_sq[0]) + SQB'(r_b_sq[1]) + SQB'(r_b_sq[2]);
            r_c_dot1 <= r_b_p1[0] + r_b_p1[1] + r_b_p1[2];
            r_c_dot2 <= r_b_p2[0] + r_b_p2[1] + r_b_p2[2];
            r_c_dot3 <= r_b_p3[0] + r_b_p3[1] + r_b_p3[2];
            r_c_lim2 <= r_b_lim2;
        end
    end

    // status and square root chain entry
    always_comb begin
        w_sq_valid[0]     = r_c_valid;
        w_sq_beat[0].rem  = r_c_sq;
        w_sq_beat[0].res  = '0;
        w_sq_beat[0].dot1 = r_c_dot1;
        w_sq_beat[0].dot2 = r_c_dot2;
        w_sq_beat[0].dot3 = r_c_dot3;
        if (r_c_sq > r_c_lim2) begin
            w_sq_beat[0].status = ST_FAR;
        end else if (r_c_sq == '0) begin
            w_sq_beat[0].status = ST_COINC;
        end else begin
            w_sq_beat[0].status = ST_OK;
        end
    end

    for (genvar g = 0; g < DB; g++) begin : g_sqrt
        ppfq_sqrt_cell #(.BIT(DB - 1 - g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sq_valid[g]),
            .i_beat  (w_sq_beat[g]),
            .o_valid (w_sq_valid[g+1]),
            .o_beat  (w_sq_beat[g+1])
        );
    end

    // stage e: divisor and dividend magnitudes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_en) begin
            r_e_valid <= w_sq_valid[DB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_status <= w_sq_beat[DB].status;
            r_e_norm   <= w_sq_beat[DB].res;
            r_e_den    <= DENB'(w_sq_beat[DB].res) * DENB'(w_astep);
            r_e_neg    <= {w_sq_beat[DB].dot3[N2B-1], w_sq_beat[DB].dot2[DOTB-1],
                           w_sq_beat[DB].dot1[DOTB-1]};
            r_e_abs[0] <= w_sq_beat[DB].dot1[DOTB-1] ? REMB'(-w_sq_beat[DB].dot1)
                                                     : REMB'(w_sq_beat[DB].dot1);
            r_e_abs[1] <= w_sq_beat[DB].dot2[DOTB-1] ? REMB'(-w_sq_beat[DB].dot2)
                                                     : REMB'(w_sq_beat[DB].dot2);
            r_e_abs[2] <= w_sq_beat[DB].dot3[N2B-1] ? REMB'(-w_sq_beat[DB].dot3)
                                                    : REMB'(w_sq_beat[DB].dot3);
        end
    end

    // divider chain entry with saturation check
    always_comb begin
        w_dv_valid[0]        = r_e_valid;
        w_dv_beat[0].status  = r_e_status;
        w_dv_beat[0].neg     = r_e_neg;
        w_dv_beat[0].quo     = '0;
        w_dv_beat[0].den[0]  = r_e_den;
        w_dv_beat[0].den[1]  = r_e_den;
        w_dv_beat[0].den[2]  = DENB'(w_astep) << NFB;
        w_dv_beat[0].den[3]  = DENB'(w_dstep);
        w_dv_beat[0].rem[0]  = r_e_abs[0];
        w_dv_beat[0].rem[1]  = r_e_abs[1];
        w_dv_beat[0].rem[2]  = r_e_abs[2];
        w_dv_beat[0].rem[3]  = REMB'(r_e_norm);
        for (int k = 0; k < 3; k++) begin
            w_dv_beat[0].sat[k] =
                CMPB'(w_dv_beat[0].rem[k]) >= (CMPB'(w_dv_beat[0].den[k]) << QB);
        end
    end

    for (genvar g = 0; g < DB; g++) begin : g_div
        ppfq_div_cell #(.SHIFT(DB - 1 - g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv_valid[g]),
            .i_beat  (w_dv_beat[g]),
            .o_valid (w_dv_valid[g+1]),
            .o_beat  (w_dv_beat[g+1])
        );
    end

    // floor sign fix and clamp of an angle key
    function automatic logic [NW-1:0] f_angle(input logic neg, input logic sat,
                                              input logic [DB-1:0] quo, input logic nz);
        logic signed [NW:0] v;
        logic signed [NW:0] lim;
        lim = $signed((NW+1)'(1) << NFB);
        if (sat) begin
            v = neg ? -lim : lim;
        end else begin
            v = $signed({2'b00, quo[QB-1:0]});
            if (neg) begin
                v = -(v + $signed((NW+1)'(nz)));
            end
        end
        if (v > lim) begin
            v = lim;
        end else if (v < -lim) begin
            v = -lim;
        end
        return v[NW-1:0];
    endfunction

    assign w_last = w_dv_beat[DB];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_k[k] = (w_last.status == ST_OK)
                   ? f_angle(w_last.neg[k], w_last.sat[k], w_last.quo[k], |w_last.rem[k])
                   : '0;
        end
        w_k4 = (w_last.status == ST_OK) ? w_last.quo[3] : '0;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= w_dv_valid[DB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_data <= TDO'({w_k4, w_k[2], w_k[1], w_k[0]});
            r_o_user <= w_last.status;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_user;

endmodule
`default_nettype wire

/* rtl/ppfq_sqrt_cell.sv */
`default_nettype none
module ppfq_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  ppfq_pkg::t_sqrt_beat i_beat,
    output logic                 o_valid,
    output ppfq_pkg::t_sqrt_beat o_beat
);
    import ppfq_pkg::*;

    logic [SQB:0] w_cand;
    t_sqrt_beat   n_beat;
    t_sqrt_beat   r_beat;
    logic         r_valid;

    // try one result bit: (res + 2^b)^2 - res^2
    always_comb begin
        n_beat = i_beat;
        w_cand = ((SQB+1)'(i_beat.res) << (BIT + 1)) | ((SQB+1)'(1) << (2 * BIT));
        if ({1'b0, i_beat.rem} >= w_cand) begin
            n_beat.rem = SQB'({1'b0, i_beat.rem} - w_cand);
            n_beat.res = i_beat.res | (DB'(1) << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule
`default_nettype wire

/* rtl/ppfq_div_cell.sv */
`default_nettype none
module ppfq_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  ppfq_pkg::t_div_beat i_beat,
    output logic                o_valid,
    output ppfq_pkg::t_div_beat o_beat
);
    import ppfq_pkg::*;

    logic [CMPB-1:0] w_sh [4];
    t_div_beat       n_beat;
    t_div_beat       r_beat;
    logic            r_valid;

    // one quotient bit on each of the four lanes
    always_comb begin
        n_beat = i_beat;
        for (int k = 0; k < 4; k++) begin
            w_sh[k] = CMPB'(i_beat.den[k]) << SHIFT;
            if (CMPB'(i_beat.rem[k]) >= w_sh[k]) begin
                n_beat.rem[k]        = REMB'(CMPB'(i_beat.rem[k]) - w_sh[k]);
                n_beat.quo[k][SHIFT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule
`default_nettype wire
